@@ rtl/core/crid_pkg.sv @@
// Shared types and constants for the column run-length image decoder.
package crid_pkg;

   localparam int CFG_W       = 11;
   localparam int ADDR_W      = 20;
   localparam int ROW_W       = 16;
   localparam int COUNT_W     = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_IDX_W   = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd320;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd200;

   // Result kinds.
   localparam logic [1:0] KIND_PIXEL      = 2'd0;
   localparam logic [1:0] KIND_UNKNOWN    = 2'd1;
   localparam logic [1:0] KIND_DROP       = 2'd2;
   localparam logic [1:0] KIND_FRAME_DONE = 2'd3;

   // Column opcodes and repeat marker constants.
   localparam logic [7:0] OPC_LITERAL = 8'h00;
   localparam logic [7:0] OPC_REPEAT  = 8'h80;
   localparam logic [7:0] OPC_SKIP    = 8'hFF;
   localparam logic [7:0] REPEAT_MIN  = 8'd224;
   localparam logic [7:0] REPEAT_BIAS = 8'd223;

   // Command operations passed from the parser to the writer.
   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_RUN     = 2'd1;
   localparam logic [1:0] OP_UNKNOWN = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] pixel_address;
      logic [7:0]        pixel_value;
      logic              last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         op;
      logic               done;
      logic [7:0]         value;
      logic [COUNT_W-1:0] count;
      logic [ROW_W-1:0]   row;
      logic [CFG_W-1:0]   column;
   } cmd_type;

endpackage

@@ rtl/core/crid_front.sv @@
// Byte parser: walks the column, packet and sequence structure and issues commands.
module crid_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  crid_pkg::req_word_type   req_word,
   input  logic [crid_pkg::CFG_W-1:0] eff_width,
   output logic                     cmd_push,
   output crid_pkg::cmd_type        cmd
);
   import crid_pkg::*;

   localparam logic [2:0] PH_OPCODE = 3'd0;
   localparam logic [2:0] PH_PACKET = 3'd1;
   localparam logic [2:0] PH_SEQCNT = 3'd2;
   localparam logic [2:0] PH_SKIP   = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_REPVAL = 3'd5;

   logic [2:0]         phase_ff, phase_in, phase_c;
   logic               mode_ff, mode_in, mode_c;
   logic [CFG_W-1:0]   column_ff, column_in, column_c;
   logic [ROW_W-1:0]   row_ff, row_in, row_c;
   logic [7:0]         ptotal_ff, ptotal_in, ptotal_c;
   logic [9:0]         pcons_ff, pcons_in, pcons_c;
   logic [7:0]         stotal_ff, stotal_in, stotal_c;
   logic [8:0]         scons_ff, scons_in, scons_c;
   logic [COUNT_W-1:0] rcount_ff, rcount_in, rcount_c;

   logic               end_seq;
   logic               end_col;
   logic [ROW_W:0]     row_sum;
   logic [CFG_W-1:0]   column_inc;
   logic [7:0]         b;

   always_comb begin
      b = req_word.data_byte;
      // A frame start clears the parse state before the byte is taken as an opcode.
      if (req_word.frame_start) begin
         phase_c  = PH_OPCODE;
         mode_c   = 1'b0;
         column_c = '0;
         row_c    = '0;
         ptotal_c = '0;
         pcons_c  = '0;
         stotal_c = '0;
         scons_c  = '0;
         rcount_c = '0;
      end else begin
         phase_c  = phase_ff;
         mode_c   = mode_ff;
         column_c = column_ff;
         row_c    = row_ff;
         ptotal_c = ptotal_ff;
         pcons_c  = pcons_ff;
         stotal_c = stotal_ff;
         scons_c  = scons_ff;
         rcount_c = rcount_ff;
      end

      phase_in   = phase_c;
      mode_in    = mode_c;
      column_in  = column_c;
      row_in     = row_c;
      ptotal_in  = ptotal_c;
      pcons_in   = pcons_c;
      stotal_in  = stotal_c;
      scons_in   = scons_c;
      rcount_in  = rcount_c;
      end_seq    = 1'b0;
      end_col    = 1'b0;
      row_sum    = '0;
      column_inc = '0;

      cmd.op     = OP_NONE;
      cmd.done   = 1'b0;
      cmd.value  = b;
      cmd.count  = COUNT_W'(1);
      cmd.row    = row_c;
      cmd.column = column_c;

      unique case (phase_c)
         PH_OPCODE: begin
            if (b == OPC_LITERAL || b == OPC_REPEAT) begin
               mode_in  = (b == OPC_REPEAT);
               phase_in = PH_PACKET;
            end else if (b == OPC_SKIP) begin
               end_col = 1'b1;
            end else begin
               cmd.op  = OP_UNKNOWN;
               end_col = 1'b1;
            end
         end
         PH_PACKET: begin
            ptotal_in = b;
            pcons_in  = '0;
            if (b == 8'd0) begin
               end_col = 1'b1;
            end else begin
               phase_in = PH_SEQCNT;
            end
         end
         PH_SEQCNT: begin
            stotal_in = b;
            scons_in  = '0;
            pcons_in  = pcons_c + 10'd1;
            phase_in  = PH_SKIP;
         end
         PH_SKIP: begin
            pcons_in = pcons_c + 10'd1;
            row_sum  = {1'b0, row_c} + (ROW_W+1)'(b);
            row_in   = row_sum[ROW_W] ? '1 : row_sum[ROW_W-1:0];
            if (stotal_c == 8'd0) begin
               end_seq = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (mode_c && b >= REPEAT_MIN) begin
               rcount_in = COUNT_W'(b - REPEAT_BIAS);
               scons_in  = scons_c + 9'd2;
               phase_in  = PH_REPVAL;
            end else begin
               cmd.op   = OP_RUN;
               row_in   = (row_c == '1) ? row_c : row_c + ROW_W'(1);
               scons_in = scons_c + 9'd1;
               if (scons_in >= {1'b0, stotal_c}) begin
                  end_seq = 1'b1;
               end
            end
         end
         PH_REPVAL: begin
            cmd.op    = OP_RUN;
            cmd.count = rcount_c;
            row_sum   = {1'b0, row_c} + (ROW_W+1)'(rcount_c);
            row_in    = row_sum[ROW_W] ? '1 : row_sum[ROW_W-1:0];
            if (scons_c >= {1'b0, stotal_c}) begin
               end_seq = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         default: begin
            phase_in = PH_OPCODE;
         end
      endcase

      if (end_seq) begin
         pcons_in = pcons_in + {2'b00, stotal_c};
         if (pcons_in >= {2'b00, ptotal_c}) begin
            end_col = 1'b1;
         end else begin
            phase_in = PH_SEQCNT;
         end
      end

      if (end_col) begin
         row_in     = '0;
         phase_in   = PH_OPCODE;
         column_inc = column_c + CFG_W'(1);
         if (column_inc >= eff_width) begin
            cmd.done  = 1'b1;
            column_in = '0;
         end else begin
            column_in = column_inc;
         end
      end

      cmd_push = accept && (cmd.op != OP_NONE || cmd.done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         mode_ff   <= 1'b0;
         column_ff <= '0;
         row_ff    <= '0;
         ptotal_ff <= '0;
         pcons_ff  <= '0;
         stotal_ff <= '0;
         scons_ff  <= '0;
         rcount_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         ptotal_ff <= ptotal_in;
         pcons_ff  <= pcons_in;
         stotal_ff <= stotal_in;
         scons_ff  <= scons_in;
         rcount_ff <= rcount_in;
      end
   end

endmodule

@@ rtl/core/crid_fifo.sv @@
// Short command queue between the parser and the pixel writer.
module crid_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  crid_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output crid_pkg::cmd_type head
);
   import crid_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/crid_back.sv @@
// Pixel writer: expands queued commands into result words through an output register.
module crid_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  crid_pkg::cmd_type          q_head,
   input  logic [crid_pkg::CFG_W-1:0] eff_height,
   input  logic                       rsp_pop,
   output logic                       q_pop,
   output logic                       rsp_empty,
   output crid_pkg::rsp_word_type     rsp_data
);
   import crid_pkg::*;

   localparam logic [2:0] BK_IDLE = 3'd0;
   localparam logic [2:0] BK_MUL  = 3'd1;
   localparam logic [2:0] BK_RUN  = 3'd2;
   localparam logic [2:0] BK_UNK  = 3'd3;
   localparam logic [2:0] BK_DONE = 3'd4;

   logic [2:0]         st_ff, st_in;
   cmd_type            ent_ff, ent_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_ff, out_in;

   logic               out_free;
   logic               emit;
   logic               finish;
   rsp_word_type       res;
   logic [2*CFG_W-1:0] product;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign product   = ent_ff.column * eff_height;

   always_comb begin
      st_in   = st_ff;
      ent_in  = ent_ff;
      base_in = base_ff;
      rem_in  = rem_ff;
      row_in  = row_ff;
      emit    = 1'b0;
      finish  = 1'b0;
      q_pop   = 1'b0;
      res     = '0;

      unique case (st_ff)
         BK_IDLE: begin
            finish = 1'b1;
         end
         BK_MUL: begin
            // Column base address is registered before the first pixel uses it.
            base_in = product[ADDR_W-1:0];
            if (ent_ff.op == OP_RUN) begin
               st_in = BK_RUN;
            end else if (ent_ff.op == OP_UNKNOWN) begin
               st_in = BK_UNK;
            end else begin
               st_in = BK_DONE;
            end
         end
         BK_RUN: begin
            if (out_free) begin
               emit              = 1'b1;
               res.pixel_value   = ent_ff.value;
               res.last_of_run   = (rem_ff == COUNT_W'(1)) && !ent_ff.done;
               if (row_ff < {{(ROW_W-CFG_W){1'b0}}, eff_height}) begin
                  res.kind          = KIND_PIXEL;
                  res.pixel_address = base_ff + ADDR_W'(row_ff);
               end else begin
                  res.kind = KIND_DROP;
               end
               row_in = (row_ff == '1) ? row_ff : row_ff + ROW_W'(1);
               rem_in = rem_ff - COUNT_W'(1);
               if (rem_ff == COUNT_W'(1)) begin
                  if (ent_ff.done) begin
                     st_in = BK_DONE;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
         end
         BK_UNK: begin
            if (out_free) begin
               emit            = 1'b1;
               res.kind        = KIND_UNKNOWN;
               res.last_of_run = !ent_ff.done;
               if (ent_ff.done) begin
                  st_in = BK_DONE;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         BK_DONE: begin
            if (out_free) begin
               emit            = 1'b1;
               res.kind        = KIND_FRAME_DONE;
               res.last_of_run = 1'b1;
               finish          = 1'b1;
            end
         end
         default: begin
            st_in = BK_IDLE;
         end
      endcase

      // Take the next command as soon as the current one is finished.
      if (finish) begin
         if (!q_empty) begin
            q_pop  = 1'b1;
            ent_in = q_head;
            rem_in = q_head.count;
            row_in = q_head.row;
            st_in  = BK_MUL;
         end else begin
            st_in = BK_IDLE;
         end
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      base_ff <= base_in;
      rem_ff  <= rem_in;
      row_ff  <= row_in;
      out_ff  <= out_in;
   end

endmodule

@@ rtl/core/column_rle_image_decoder.sv @@
// Column run-length image decoder: takes one encoded byte per word and writes pixels.
// A byte enters the parser whenever the four-entry command queue has room; bytes
// that produce no result leave nothing in the queue. Each byte that produces results
// becomes one queued command, and the writer first registers the column base
// address (column times height, one multiply) and then emits the result words: one
// for a plain pixel, up to 32 for a repeat run, plus one for an unknown-opcode or
// frame-complete word. The parser keeps taking bytes while the writer works, and
// the input reports full while long repeat runs drain. The user must write width and
// height on the csr port only while the block is idle; the block itself does not
// enforce it. Values above MAX_WIDTH and MAX_HEIGHT act as those limits.
module column_rle_image_decoder #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  crid_pkg::req_word_type         req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output crid_pkg::rsp_word_type         rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [crid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [crid_pkg::CFG_W-1:0]     csr_wdata
);
   import crid_pkg::*;

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [CFG_W-1:0] eff_width;
   logic [CFG_W-1:0] eff_height;
   logic             accept;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   cmd_type          q_in;
   cmd_type          q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign eff_width  = (int'(frame_width_ff) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : frame_width_ff;
   assign eff_height = (int'(frame_height_ff) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT)
                                                            : frame_height_ff;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   crid_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_data),
      .eff_width (eff_width),
      .cmd_push  (q_push),
      .cmd       (q_in)
   );

   crid_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   crid_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .eff_height (eff_height),
      .rsp_pop    (rsp_pop),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

   // The writer never takes a command from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("command popped from empty queue");

   // Only pixel writes carry an address.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind != KIND_PIXEL) |-> rsp_data.pixel_address == '0)
      else $error("non-pixel result with nonzero address");

   // Frame complete is always the final word of its byte.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == KIND_FRAME_DONE) |-> rsp_data.last_of_run)
      else $error("frame complete not marked last");

   // A pixel write can only happen when the frame has a nonzero height.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == KIND_PIXEL) |-> eff_height != '0)
      else $error("pixel written with zero height");

endmodule
